// ----- src/mic_dc_block_and_voice_activity_assert.svh -----
// Assertion macros for the mic DC block and voice activity block.
`ifndef MIC_DC_BLOCK_AND_VOICE_ACTIVITY_ASSERT_SVH
`define MIC_DC_BLOCK_AND_VOICE_ACTIVITY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MDV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MDV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/mdv_pkg.sv -----
`timescale 1ns / 1ps
package mdv_pkg;
  localparam int ChunkMax = 1024;
  localparam int CntW = 11;
  localparam int SumW = 26;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_START  = 2'd1;
  localparam logic [1:0] MODE_STOP   = 2'd2;
  localparam logic [1:0] MODE_ABORT  = 2'd3;

  localparam logic [2:0] REG_COEFF        = 3'd0;
  localparam logic [2:0] REG_VAD_THRESH   = 3'd1;
  localparam logic [2:0] REG_SPEECH_TMO   = 3'd2;
  localparam logic [2:0] REG_INITIAL_TMO  = 3'd3;
  localparam logic [2:0] REG_FLUSH_CHUNKS = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;
endpackage

// ----- src/mdv_mul.sv -----
`timescale 1ns / 1ps
// Bit-serial signed x unsigned multiply, one coefficient bit per cycle.
module mdv_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic        [15:0] coeff,
  output logic signed [32:0] fb,
  output logic               done
);
  logic [32:0] amag;
  logic [15:0] b;
  logic [48:0] prod;
  logic [3:0]  cnt;
  logic        busy;
  logic        neg;
  logic [32:0] aext;
  logic [33:0] psum;
  logic [32:0] mag;

  assign aext = {a[31], a};
  assign psum = {1'b0, prod[48:16]} + (b[0] ? {1'b0, amag} : 34'd0);
  assign mag  = prod[48:16];
  assign fb   = neg ? $signed(~mag + 33'd1) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'd15;
        neg  <= aext[32];
        amag <= aext[32] ? (~aext + 33'd1) : aext;
        b    <= coeff;
        prod <= '0;
      end else if (busy) begin
        prod <= {psum, prod[15:1]};
        b    <= {1'b0, b[15:1]};
        cnt  <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- src/mdv_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module mdv_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mdv_pkg::SumW-1:0]   dividend,
  input  logic [mdv_pkg::CntW-1:0]   divisor,
  output logic [15:0]                quotient,
  output logic                       done
);
  logic [mdv_pkg::SumW-1:0] q;
  logic [mdv_pkg::CntW-1:0] d;
  logic [mdv_pkg::CntW-1:0] rem;
  logic [4:0]               cnt;
  logic                     busy;
  logic [mdv_pkg::CntW:0]   trial;
  logic                     ge;

  assign trial    = {rem, q[mdv_pkg::SumW-1]};
  assign ge       = trial >= {1'b0, d};
  assign quotient = q[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(mdv_pkg::SumW - 1);
        q    <= dividend;
        d    <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= ge ? mdv_pkg::CntW'(trial - {1'b0, d}) : trial[mdv_pkg::CntW-1:0];
        q   <= {q[mdv_pkg::SumW-2:0], ge};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- src/mic_dc_block_and_voice_activity.sv -----
`timescale 1ns / 1ps
// A sample passes the MUL, ADD, (on a chunk close) DIV and FIN, and OUT states; s_tready is
// high only in IDLE, so no item is taken until the previous sample is through; control items stay in IDLE.
// The 16-step serial feedback multiplier and the 26-step serial divider do the slow work.
// Reset: synchronous, active high; clears filter history, session state and the registers
// to their defaults (coefficient 65208, threshold 500, timeouts 1500/5000 ms, flush 20).
module mic_dc_block_and_voice_activity (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // raw_word
  input  logic [1:0]  s_tuser,   // mode
  input  logic        s_tlast,   // chunk_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // filtered_sample, chunk_average
  output logic [2:0]  m_tuser,   // voice_active, stop_armed, stream_finished
  output logic        m_tlast,   // chunk_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  mdv_pkg::state_t state, state_next;

  logic [15:0] fb_coeff, vad_threshold, speech_tmo, initial_tmo;
  logic [7:0]  flush_count;

  logic signed [15:0] prev_input;
  logic signed [31:0] prev_output;
  logic        streaming, speech_heard, stop_pending;
  logic [31:0] silence_ms;
  logic [7:0]  flush_left;
  logic [mdv_pkg::SumW-1:0] abs_sum;
  logic [mdv_pkg::CntW-1:0] chunk_samples;

  logic signed [15:0] x;
  logic        chunk_end;
  logic signed [15:0] ys;
  logic        closing, finished;

  logic        mul_start, mul_done, div_start, div_done;
  logic signed [32:0] fb;
  logic [15:0] quotient;

  logic        accept;
  logic signed [34:0] y;
  logic signed [15:0] ys_c;
  logic [15:0] mag;
  logic [mdv_pkg::SumW-1:0] sum_next;
  logic [mdv_pkg::CntW-1:0] cnt_next;
  logic        close_now;
  logic        voice;
  logic        voice_q;
  logic [32:0] sil_sum;
  logic [31:0] sil_new;
  logic        heard_new;
  logic [15:0] timeout;
  logic        out_free;

  assign s_tready  = (state == mdv_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign mul_start = accept && s_tuser == mdv_pkg::MODE_SAMPLE && streaming;

  mdv_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(prev_output),
    .coeff(fb_coeff), .fb(fb), .done(mul_done)
  );

  assign y = 35'(x) - 35'(prev_input) + 35'(fb);
  always_comb begin
    if (y > 35'sd32767) ys_c = 16'sd32767;
    else if (y < -35'sd32768) ys_c = -16'sd32768;
    else ys_c = y[15:0];
  end
  assign mag       = ys_c[15] ? 16'(-ys_c) : ys_c;
  assign sum_next  = abs_sum + mdv_pkg::SumW'(mag);
  assign cnt_next  = chunk_samples + mdv_pkg::CntW'(1);
  assign close_now = chunk_end || (cnt_next == mdv_pkg::CntW'(mdv_pkg::ChunkMax));
  assign div_start = (state == mdv_pkg::ST_ADD) && close_now;

  mdv_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum_next),
    .divisor(cnt_next), .quotient(quotient), .done(div_done)
  );

  assign voice     = quotient > vad_threshold;
  assign sil_sum   = {1'b0, silence_ms} + 33'(chunk_samples[mdv_pkg::CntW-1:4]);
  assign sil_new   = voice ? 32'd0 : (sil_sum[32] ? 32'hFFFF_FFFF : sil_sum[31:0]);
  assign heard_new = speech_heard || voice;
  assign timeout   = heard_new ? speech_tmo : initial_tmo;

  always_comb begin
    state_next = state;
    case (state)
      mdv_pkg::ST_IDLE: if (mul_start) state_next = mdv_pkg::ST_MUL;
      mdv_pkg::ST_MUL:  if (mul_done) state_next = mdv_pkg::ST_ADD;
      mdv_pkg::ST_ADD:  state_next = close_now ? mdv_pkg::ST_DIV : mdv_pkg::ST_OUT;
      mdv_pkg::ST_DIV:  if (div_done) state_next = mdv_pkg::ST_FIN;
      mdv_pkg::ST_FIN:  state_next = mdv_pkg::ST_OUT;
      mdv_pkg::ST_OUT:  if (out_free) state_next = mdv_pkg::ST_IDLE;
      default:          state_next = mdv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mdv_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_coeff      <= 16'd65208;
      vad_threshold <= 16'd500;
      speech_tmo    <= 16'd1500;
      initial_tmo   <= 16'd5000;
      flush_count   <= 8'd20;
      prev_input    <= '0;
      prev_output   <= '0;
      streaming     <= 1'b0;
      speech_heard  <= 1'b0;
      stop_pending  <= 1'b0;
      silence_ms    <= '0;
      flush_left    <= '0;
      abs_sum       <= '0;
      chunk_samples <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mdv_pkg::REG_COEFF:        fb_coeff      <= cfg_data;
          mdv_pkg::REG_VAD_THRESH:   vad_threshold <= cfg_data;
          mdv_pkg::REG_SPEECH_TMO:   speech_tmo    <= cfg_data;
          mdv_pkg::REG_INITIAL_TMO:  initial_tmo   <= cfg_data;
          mdv_pkg::REG_FLUSH_CHUNKS: flush_count   <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        case (s_tuser)
          mdv_pkg::MODE_START: if (!streaming) begin
            streaming     <= 1'b1;
            speech_heard  <= 1'b0;
            silence_ms    <= '0;
            abs_sum       <= '0;
            chunk_samples <= '0;
          end
          mdv_pkg::MODE_STOP: begin
            stop_pending <= 1'b1;
            flush_left   <= flush_count;
          end
          mdv_pkg::MODE_ABORT: streaming <= 1'b0;
          default: begin
            x         <= $signed(s_tdata[29:14]);
            chunk_end <= s_tlast;
          end
        endcase
      end
      if (state == mdv_pkg::ST_ADD) begin
        prev_input    <= x;
        prev_output   <= y[31:0];
        ys            <= ys_c;
        abs_sum       <= sum_next;
        chunk_samples <= cnt_next;
        closing       <= close_now;
        finished      <= close_now && stop_pending && (flush_left == 8'd0);
        if (close_now && stop_pending) begin
          if (flush_left != 8'd0) begin
            flush_left <= flush_left - 8'd1;
          end else begin
            streaming    <= 1'b0;
            stop_pending <= 1'b0;
          end
        end
      end
      if (state == mdv_pkg::ST_FIN) begin
        speech_heard  <= heard_new;
        if (sil_new >= 32'(timeout) && !stop_pending) begin
          stop_pending <= 1'b1;
          flush_left   <= flush_count;
          silence_ms   <= '0;
        end else begin
          silence_ms   <= sil_new;
        end
        abs_sum       <= '0;
        chunk_samples <= '0;
      end
      if (state == mdv_pkg::ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
        m_tlast  <= closing;
        if (closing) begin
          m_tdata <= {quotient, ys};
          m_tuser <= {finished, stop_pending, voice_q};
        end else begin
          m_tdata <= {16'd0, ys};
          m_tuser <= 3'd0;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == mdv_pkg::ST_FIN) voice_q <= voice;
  end
endmodule

// ----- src/mdv_checker.sv -----
`timescale 1ns / 1ps
`include "mic_dc_block_and_voice_activity_assert.svh"
module mdv_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);
  `MDV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  `MDV_ASSERT_NOW(a_open_zero, m_tvalid && !m_tlast, m_tdata[31:16] == 16'd0 && m_tuser == 3'd0)
  `MDV_ASSERT_NOW(a_fin_close, m_tvalid && m_tuser[2], m_tlast)
  `MDV_ASSERT_NOW(a_avg_range, m_tvalid && m_tlast, m_tdata[31:16] <= 16'd32768)
  `MDV_ASSERT_NOW(a_rst_empty, $past(rst), !m_tvalid)
endmodule

bind mic_dc_block_and_voice_activity mdv_checker u_mdv_checker (
  .clk(clk), .rst(rst),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
  .m_tuser(m_tuser), .m_tlast(m_tlast)
);

// ----- tb/tb_mic_dc_block_and_voice_activity.sv -----
`timescale 1ns / 1ps
module tb_mic_dc_block_and_voice_activity;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] word;
    logic        cend;
  } mic_item_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
    logic [15:0] avg;
    logic        voice;
    logic        armed;
    logic        fin;
  } dc_result_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [31:0] s_tdata = 0;
  logic [1:0] s_tuser = 0;
  logic s_tlast = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [31:0] m_tdata;
  logic [2:0] m_tuser;
  logic m_tlast;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  always #5 clk = ~clk;

  mic_dc_block_and_voice_activity DUT (.*);

  // predictor state
  logic [15:0] p_coeff, p_thresh, p_speech_tmo, p_init_tmo;
  logic [7:0] p_flush_cnt;
  logic signed [15:0] p_prev_in;
  logic [31:0] p_prev_out;
  logic p_streaming, p_heard, p_stop;
  logic [31:0] p_silence;
  logic [7:0] p_flush_left;
  logic [25:0] p_sum;
  logic [10:0] p_count;

  mic_item_t pending_items[$];
  dc_result_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int chunks_seen = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  bit sender_pause = 0;
  bit in_taken = 0;
  bit out_taken = 0;
  int send_wait = 0;
  int recv_wait = 0;

  task automatic predict_dc_block(input mic_item_t it);
    logic signed [15:0] x;
    logic signed [63:0] fb, y;
    logic signed [15:0] ys;
    logic [15:0] mag;
    logic closing;
    logic [31:0] avg, tmo, add;
    logic voice, fin;
    dc_result_t r;
    closing = it.cend;
    voice = 0;
    fin = 0;
    avg = 0;
    case (it.mode)
      mdv_pkg::MODE_START: begin
        if (!p_streaming) begin
          p_streaming = 1; p_heard = 0; p_silence = 0; p_sum = 0; p_count = 0;
        end
      end
      mdv_pkg::MODE_STOP: begin
        p_stop = 1; p_flush_left = p_flush_cnt;
      end
      mdv_pkg::MODE_ABORT: p_streaming = 0;
      default: begin
        if (p_streaming) begin
          x = it.word[29:14];
          fb = ($signed({{32{p_prev_out[31]}}, p_prev_out}) * $signed({48'd0, p_coeff}));
          fb = fb / 65536;
          y = 64'(x) - 64'(p_prev_in) + fb;
          p_prev_in = x;
          p_prev_out = y[31:0];
          if (y > 32767) ys = 16'sd32767;
          else if (y < -32768) ys = -16'sd32768;
          else ys = y[15:0];
          mag = ys < 0 ? -ys : ys;
          p_sum = p_sum + 26'(mag);
          p_count = p_count + 11'd1;
          if (p_count >= mdv_pkg::ChunkMax) closing = 1;
          if (closing) begin
            if (p_stop) begin
              if (p_flush_left > 0) p_flush_left = p_flush_left - 8'd1;
              else begin
                p_streaming = 0; p_stop = 0; fin = 1;
              end
            end
            avg = p_count != 0 ? 32'(p_sum) / 32'(p_count) : 32'd0;
            if (avg > p_thresh) begin
              voice = 1; p_silence = 0; p_heard = 1;
            end else begin
              add = (32'(p_count) * 1000) / 16000;
              if (p_silence > 32'hFFFFFFFF - add) p_silence = 32'hFFFFFFFF;
              else p_silence = p_silence + add;
            end
            tmo = p_heard ? p_speech_tmo : p_init_tmo;
            if (p_silence >= tmo && !p_stop) begin
              p_stop = 1; p_flush_left = p_flush_cnt; p_silence = 0;
            end
            p_sum = 0;
            p_count = 0;
          end
          r.sample = ys;
          r.last = closing;
          r.avg = closing ? avg[15:0] : 16'd0;
          r.voice = closing & voice;
          r.armed = closing & p_stop;
          r.fin = closing & fin;
          expected_results.push_back(r);
        end
      end
    endcase
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        in_taken = 0;
        s_tvalid <= 0;
        send_wait = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) send_wait = 0;
      end else if (!s_tvalid && !sender_pause && pending_items.size() > 0) begin
        if (send_wait > 0) send_wait--;
        else begin
          mic_item_t it;
          it = pending_items.pop_front();
          s_tuser <= it.mode;
          s_tdata <= it.word;
          s_tlast <= it.cend;
          s_tvalid <= 1;
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) begin
        out_taken = 0;
        recv_wait = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) recv_wait = 0;
      end
      if (hold_off > 0) begin
        hold_off--;
        m_tready <= 0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        m_tready <= 0;
      end else m_tready <= 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("timeout waiting for transfers");
        $display("DONE: errors detected");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        dc_result_t e;
        results_seen++;
        out_taken = 1;
        if (expected_results.size() == 0) begin
          $error("result with no expectation: tdata %h", m_tdata);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (m_tlast) chunks_seen++;
          if (m_tdata[15:0] !== e.sample) begin
            $error("filtered_sample exp %0d got %0d", $signed(e.sample),
                   $signed(m_tdata[15:0]));
            errors++;
          end
          if (m_tlast !== e.last) begin
            $error("chunk_last exp %0d got %0d", e.last, m_tlast); errors++;
          end
          if (m_tdata[31:16] !== e.avg) begin
            $error("chunk_average exp %0d got %0d", e.avg, m_tdata[31:16]); errors++;
          end
          if (m_tuser[0] !== e.voice) begin
            $error("voice_active exp %0d got %0d", e.voice, m_tuser[0]); errors++;
          end
          if (m_tuser[1] !== e.armed) begin
            $error("stop_armed exp %0d got %0d", e.armed, m_tuser[1]); errors++;
          end
          if (m_tuser[2] !== e.fin) begin
            $error("stream_finished exp %0d got %0d", e.fin, m_tuser[2]); errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_dc_block({s_tuser, s_tdata, s_tlast});
        in_taken = 1;
      end
    end
  end

  task automatic add_item(input logic [1:0] mode, input logic [31:0] word, input logic cend);
    mic_item_t it;
    it.mode = mode;
    it.word = word;
    it.cend = cend;
    pending_items.push_back(it);
  endtask

  task automatic drain;
    while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    case (idx)
      mdv_pkg::REG_COEFF: p_coeff = val;
      mdv_pkg::REG_VAD_THRESH: p_thresh = val;
      mdv_pkg::REG_SPEECH_TMO: p_speech_tmo = val;
      mdv_pkg::REG_INITIAL_TMO: p_init_tmo = val;
      mdv_pkg::REG_FLUSH_CHUNKS: p_flush_cnt = val[7:0];
      default: ;
    endcase
  endtask

  task automatic random_session(input int n);
    int amp;
    amp = $urandom_range(0, 3);
    add_item(mdv_pkg::MODE_START, $urandom, 1'($urandom_range(0, 1)));
    for (int i = 0; i < n; i++) begin
      int r;
      logic [31:0] w;
      r = $urandom_range(0, 99);
      case (amp)
        0: w = $urandom;
        1: w = 32'($signed($urandom_range(0, 4000)) - 2000);
        2: w = {$urandom_range(0, 1) ? 2'b11 : 2'b00, 30'($urandom)};
        default: w = 32'($signed($urandom_range(0, 400000)) - 200000) <<< 14;
      endcase
      if (r < 2) add_item(mdv_pkg::MODE_STOP, $urandom, 1'($urandom_range(0, 1)));
      else if (r < 3) add_item(mdv_pkg::MODE_ABORT, $urandom, 1'($urandom_range(0, 1)));
      else if (r < 4) add_item(mdv_pkg::MODE_START, $urandom, 1'($urandom_range(0, 1)));
      else add_item(mdv_pkg::MODE_SAMPLE, w, $urandom_range(0, 15) == 0);
    end
  endtask

  initial begin
    p_coeff = 65208; p_thresh = 500; p_speech_tmo = 1500; p_init_tmo = 5000;
    p_flush_cnt = 20;
    p_prev_in = 0; p_prev_out = 0; p_streaming = 0; p_heard = 0; p_stop = 0;
    p_silence = 0; p_flush_left = 0; p_sum = 0; p_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, all modes, ignored sample, start while streaming
    add_item(mdv_pkg::MODE_SAMPLE, 32'h7FFFFFFF, 1'b1);
    add_item(mdv_pkg::MODE_START, 32'd0, 1'b0);
    add_item(mdv_pkg::MODE_START, 32'd0, 1'b0);
    add_item(mdv_pkg::MODE_SAMPLE, 32'h7FFFFFFF, 1'b0);
    add_item(mdv_pkg::MODE_SAMPLE, 32'h80000000, 1'b0);
    add_item(mdv_pkg::MODE_SAMPLE, 32'h1FFFC000, 1'b0);
    add_item(mdv_pkg::MODE_SAMPLE, 32'hE0000000, 1'b0);
    add_item(mdv_pkg::MODE_SAMPLE, 32'hFFFFFFFF, 1'b0);
    add_item(mdv_pkg::MODE_SAMPLE, 32'h00000000, 1'b1);
    add_item(mdv_pkg::MODE_STOP, 32'hFFFFFFFF, 1'b1);
    add_item(mdv_pkg::MODE_SAMPLE, 32'h20000000, 1'b1);
    add_item(mdv_pkg::MODE_SAMPLE, 32'h40000000, 1'b1);
    add_item(mdv_pkg::MODE_ABORT, 32'd0, 1'b1);
    add_item(mdv_pkg::MODE_SAMPLE, 32'h12345678, 1'b1);
    drain();

    write_reg(mdv_pkg::REG_COEFF, 16'hFFFF);
    write_reg(mdv_pkg::REG_VAD_THRESH, 16'd0);
    write_reg(mdv_pkg::REG_SPEECH_TMO, 16'd0);
    write_reg(mdv_pkg::REG_INITIAL_TMO, 16'd0);
    write_reg(mdv_pkg::REG_FLUSH_CHUNKS, 16'd0);
    add_item(mdv_pkg::MODE_START, 32'd0, 1'b0);
    for (int i = 0; i < 8; i++) add_item(mdv_pkg::MODE_SAMPLE, 32'h7FFFFFFF, i % 3 == 2);
    add_item(mdv_pkg::MODE_START, 32'd0, 1'b0);
    for (int i = 0; i < 6; i++) add_item(mdv_pkg::MODE_SAMPLE, 32'h80000000, 1'(i % 2));
    drain();

    // long receiver stall while the sender keeps offering
    write_reg(mdv_pkg::REG_COEFF, 16'd65208);
    write_reg(mdv_pkg::REG_VAD_THRESH, 16'd500);
    write_reg(mdv_pkg::REG_SPEECH_TMO, 16'd20);
    write_reg(mdv_pkg::REG_INITIAL_TMO, 16'd40);
    write_reg(mdv_pkg::REG_FLUSH_CHUNKS, 16'd2);
    random_session(60);
    hold_off = 2000;
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(mdv_pkg::REG_COEFF, $urandom_range(0, 1) ? 16'($urandom) : 16'hFF00);
      write_reg(mdv_pkg::REG_VAD_THRESH, 16'($urandom_range(0, 3000)));
      write_reg(mdv_pkg::REG_SPEECH_TMO, 16'($urandom_range(0, 80)));
      write_reg(mdv_pkg::REG_INITIAL_TMO, 16'($urandom_range(0, 160)));
      write_reg(mdv_pkg::REG_FLUSH_CHUNKS, 16'($urandom_range(0, 4)));
      random_session(100);
      // sender pause until all results are in
      while (pending_items.size() > 50) @(posedge clk);
      sender_pause = 1;
      while (s_tvalid || expected_results.size() > 0) @(posedge clk);
      repeat (60) @(posedge clk);
      sender_pause = 0;
      drain();
    end

    $display("covered control modes, extreme words, stop/flush, timeouts and output stalls");
    $display("results checked: %0d, chunks closed: %0d", results_seen, chunks_seen);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+src
src/mdv_pkg.sv
src/mdv_mul.sv
src/mdv_div.sv
src/mic_dc_block_and_voice_activity.sv
src/mdv_checker.sv
tb/tb_mic_dc_block_and_voice_activity.sv
